/* rtl/gra_pkg.sv */
// gra_pkg: shared types for the grid rectangle allocator
// payload structs, operation codes, controller/datapath command and status
// no dependencies
`default_nettype none
package gra_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_ROWS_DEF    = 16;
  localparam int ID_BITS_DEF     = 16;

  // coordinates and sums of a 4-bit position and a 5-bit size
  localparam int KW = 7;

  localparam logic [1:0] RES_FAIL    = 2'd0;
  localparam logic [1:0] RES_OK      = 2'd1;
  localparam logic [1:0] RES_INVALID = 2'd2;

  localparam logic [3:0] CFG_COLUMNS = 4'd0;
  localparam logic [3:0] CFG_ROWS    = 4'd1;

  typedef enum logic [2:0] {
    OP_PLACE     = 3'd0,
    OP_HOLD      = 3'd1,
    OP_PICK      = 3'd2,
    OP_CHECK     = 3'd3,
    OP_FIND_ROOM = 3'd4,
    OP_FIND_ITEM = 3'd5,
    OP_NEXT_ITEM = 3'd6,
    OP_CLEAR     = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  pos_x;
    logic [3:0]  pos_y;
    logic [15:0] owner_id;
    logic [4:0]  rect_width;
    logic [4:0]  rect_height;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [15:0] found_id;
    logic [3:0]  found_x;
    logic [3:0]  found_y;
  } out_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_RECT_RD, S_RECT_CHK, S_FILL,
    S_FI_V, S_FI_L, S_FI_U, S_NX_RD, S_NX_CHK, S_NX_UP, S_CLR, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    A_RECT, A_BASE, A_LEFT, A_UP, A_SWEEP
  } addr_sel_t;

  typedef enum logic [1:0] {
    IDS_NONE, IDS_V, IDS_RD
  } id_sel_t;

  typedef struct packed {
    logic       load_req;
    logic       cand_init;
    logic       cand_next;
    logic       off_init;
    logic       off_next;
    logic       pos_next;
    logic       latch_v;
    logic       sweep_init;
    logic       sweep_next;
    logic       mem_we;
    logic       wr_id;
    addr_sel_t  addr_sel;
    logic       cmp_id;
    logic       res_load;
    logic [1:0] res_code;
    id_sel_t    res_id_sel;
    logic       res_pos;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic rect_in;
    logic hold_ok;
    logic id_zero;
    logic last_cand;
    logic last_cell;
    logic eq_tgt;
    logic pos_in;
    logic pos_last;
    logic p_zero;
    logic row0;
    logic rd_zero;
    logic rd_id;
    logic rd_eq_v;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/gra_ram.sv */
// gra_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module gra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/gra_ctrl.sv */
// gra_ctrl: request sequencer of the grid rectangle allocator
// depends on gra_pkg
`default_nettype none
module gra_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire gra_pkg::stat_t st,
  output gra_pkg::cmd_t       cmd
);
  import gra_pkg::*;

  state_t state, state_next;
  logic   searching;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign searching = st.op inside {OP_HOLD, OP_FIND_ROOM};

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.addr_sel = A_SWEEP;
        cmd.mem_we   = 1'b1;
        if (st.sweep_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.sweep_next = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.off_init = 1'b1;
        cmd.addr_sel = A_BASE;
        case (st.op)
          OP_PLACE, OP_PICK, OP_CHECK: begin
            if (!st.rect_in || (st.op == OP_PLACE && st.id_zero)) begin
              cmd.res_load = 1'b1;
              cmd.res_code = RES_FAIL;
              state_next   = S_DONE;
            end else begin
              state_next = S_RECT_RD;
            end
          end
          OP_HOLD, OP_FIND_ROOM: begin
            if (!st.hold_ok || (st.op == OP_HOLD && st.id_zero)) begin
              cmd.res_load = 1'b1;
              cmd.res_code = RES_FAIL;
              state_next   = S_DONE;
            end else begin
              cmd.cand_init = 1'b1;
              state_next    = S_RECT_RD;
            end
          end
          OP_FIND_ITEM: begin
            if (!st.pos_in) begin
              cmd.res_load = 1'b1;
              cmd.res_code = RES_INVALID;
              state_next   = S_DONE;
            end else begin
              state_next = S_FI_V;
            end
          end
          OP_NEXT_ITEM: begin
            if (!st.pos_in) begin
              cmd.res_load = 1'b1;
              cmd.res_code = RES_FAIL;
              state_next   = S_DONE;
            end else begin
              state_next = S_NX_RD;
            end
          end
          default: begin
            cmd.sweep_init = 1'b1;
            state_next     = S_CLR;
          end
        endcase
      end
      S_RECT_RD: begin
        cmd.addr_sel = A_RECT;
        state_next   = S_RECT_CHK;
      end
      S_RECT_CHK: begin
        cmd.cmp_id = (st.op == OP_PICK);
        if (st.eq_tgt && !st.last_cell) begin
          cmd.off_next = 1'b1;
          state_next   = S_RECT_RD;
        end else if (st.eq_tgt) begin
          if (st.op inside {OP_CHECK, OP_FIND_ROOM}) begin
            cmd.res_load = 1'b1;
            cmd.res_code = RES_OK;
            cmd.res_pos  = (st.op == OP_FIND_ROOM);
            state_next   = S_DONE;
          end else begin
            cmd.off_init = 1'b1;
            state_next   = S_FILL;
          end
        end else if (searching && !st.last_cand) begin
          cmd.cand_next = 1'b1;
          cmd.off_init  = 1'b1;
          state_next    = S_RECT_RD;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_FAIL;
          state_next   = S_DONE;
        end
      end
      S_FILL: begin
        cmd.addr_sel = A_RECT;
        cmd.mem_we   = 1'b1;
        cmd.wr_id    = (st.op != OP_PICK);
        if (st.last_cell) begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_OK;
          state_next   = S_DONE;
        end else begin
          cmd.off_next = 1'b1;
        end
      end
      S_FI_V: begin
        cmd.latch_v = 1'b1;
        if (st.rd_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_FAIL;
          state_next   = S_DONE;
        end else if (!st.p_zero) begin
          cmd.addr_sel = A_LEFT;
          state_next   = S_FI_L;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_code   = RES_OK;
          cmd.res_id_sel = IDS_RD;
          state_next     = S_DONE;
        end
      end
      S_FI_L: begin
        cmd.addr_sel = A_UP;
        if (st.rd_eq_v) begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_INVALID;
          state_next   = S_DONE;
        end else if (!st.row0) begin
          state_next = S_FI_U;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_code   = RES_OK;
          cmd.res_id_sel = IDS_V;
          state_next     = S_DONE;
        end
      end
      S_FI_U: begin
        cmd.res_load   = 1'b1;
        state_next     = S_DONE;
        if (st.rd_eq_v) begin
          cmd.res_code = RES_INVALID;
        end else begin
          cmd.res_code   = RES_OK;
          cmd.res_id_sel = IDS_V;
        end
      end
      S_NX_RD: begin
        cmd.addr_sel = A_BASE;
        state_next   = S_NX_CHK;
      end
      S_NX_CHK: begin
        cmd.latch_v  = 1'b1;
        cmd.addr_sel = A_UP;
        if (st.rd_zero || st.rd_id) begin
          if (st.pos_last) begin
            cmd.res_load = 1'b1;
            cmd.res_code = RES_FAIL;
            state_next   = S_DONE;
          end else begin
            cmd.pos_next = 1'b1;
            state_next   = S_NX_RD;
          end
        end else if (st.row0) begin
          cmd.res_load   = 1'b1;
          cmd.res_code   = RES_OK;
          cmd.res_id_sel = IDS_RD;
          cmd.res_pos    = 1'b1;
          state_next     = S_DONE;
        end else begin
          state_next = S_NX_UP;
        end
      end
      S_NX_UP: begin
        if (!st.rd_eq_v) begin
          cmd.res_load   = 1'b1;
          cmd.res_code   = RES_OK;
          cmd.res_id_sel = IDS_V;
          cmd.res_pos    = 1'b1;
          state_next     = S_DONE;
        end else if (st.pos_last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_FAIL;
          state_next   = S_DONE;
        end else begin
          cmd.pos_next = 1'b1;
          state_next   = S_NX_RD;
        end
      end
      S_CLR: begin
        cmd.addr_sel = A_SWEEP;
        cmd.mem_we   = 1'b1;
        if (st.sweep_last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_OK;
          state_next   = S_DONE;
        end else begin
          cmd.sweep_next = 1'b1;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/gra_datapath.sv */
// gra_datapath: grid memory, request registers, walk counters, result registers
// depends on gra_pkg and gra_ram
`default_nettype none
module gra_datapath #(
  parameter int MAX_COLUMNS = gra_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gra_pkg::MAX_ROWS_DEF,
  parameter int ID_BITS     = gra_pkg::ID_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire gra_pkg::in_t  in_data,
  input  wire logic          cfg_valid,
  input  wire logic [3:0]    cfg_index,
  input  wire logic [4:0]    cfg_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output gra_pkg::out_t      out_data,
  input  wire gra_pkg::cmd_t cmd,
  output gra_pkg::stat_t     st
);
  import gra_pkg::*;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COLS_RST = (16 > MAX_COLUMNS) ? MAX_COLUMNS : 16;
  localparam int ROWS_RST = (16 > MAX_ROWS) ? MAX_ROWS : 16;

  logic [KW-1:0]      cols, rows;
  logic [2:0]         req_op;
  logic [ID_BITS-1:0] req_id;
  logic [KW-1:0]      req_w, req_h;
  logic [KW-1:0]      bx, by, ci, cj;
  logic [ID_BITS-1:0] v;
  logic [AW-1:0]      sweep;
  out_t               res;

  logic [KW-1:0]      row, col;
  logic [2*KW-1:0]    lin;
  logic [AW-1:0]      addr;
  logic [ID_BITS-1:0] rd_data, wdata;
  logic [4:0]         cfg_v;

  assign cfg_v = (cfg_data == 5'd0) ? 5'd1 : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= KW'(COLS_RST);
      rows <= KW'(ROWS_RST);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_COLUMNS) begin
        cols <= (32'(cfg_v) > 32'(MAX_COLUMNS)) ? KW'(MAX_COLUMNS) : KW'(cfg_v);
      end else if (cfg_index == CFG_ROWS) begin
        rows <= (32'(cfg_v) > 32'(MAX_ROWS)) ? KW'(MAX_ROWS) : KW'(cfg_v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op <= in_data.operation;
      req_id <= ID_BITS'(in_data.owner_id);
      req_w  <= KW'(in_data.rect_width);
      req_h  <= KW'(in_data.rect_height);
      bx     <= KW'(in_data.pos_x);
      by     <= KW'(in_data.pos_y);
    end else if (cmd.cand_init) begin
      bx <= '0;
      by <= '0;
    end else if (cmd.cand_next) begin
      if (by + req_h == rows) begin
        by <= '0;
        bx <= bx + KW'(1);
      end else begin
        by <= by + KW'(1);
      end
    end else if (cmd.pos_next) begin
      if (bx + KW'(1) == cols) begin
        bx <= '0;
        by <= by + KW'(1);
      end else begin
        bx <= bx + KW'(1);
      end
    end
    if (cmd.off_init) begin
      ci <= '0;
      cj <= '0;
    end else if (cmd.off_next) begin
      if (cj + KW'(1) == req_h) begin
        cj <= '0;
        ci <= ci + KW'(1);
      end else begin
        cj <= cj + KW'(1);
      end
    end
    if (cmd.latch_v) begin
      v <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_init) begin
      sweep <= '0;
    end else if (cmd.sweep_next) begin
      sweep <= sweep + AW'(1);
    end
  end

  // cell (x,y) lives at y*cols+x
  always_comb begin
    row = (cmd.addr_sel == A_RECT) ? by + cj : by;
    col = (cmd.addr_sel == A_RECT) ? bx + ci : bx;
    lin = (2*KW)'(row) * (2*KW)'(cols) + (2*KW)'(col);
    case (cmd.addr_sel)
      A_LEFT:  addr = AW'(lin - (2*KW)'(1));
      A_UP:    addr = AW'(lin - (2*KW)'(cols));
      A_SWEEP: addr = sweep;
      default: addr = AW'(lin);
    endcase
  end

  assign wdata = cmd.wr_id ? req_id : '0;

  gra_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.mem_we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rd_data)
  );

  always_comb begin
    st.op         = op_t'(req_op);
    st.rect_in    = (req_w != '0) && (req_h != '0) &&
                    (bx + req_w <= cols) && (by + req_h <= rows);
    st.hold_ok    = (req_w != '0) && (req_h != '0) &&
                    (req_w <= cols) && (req_h <= rows);
    st.id_zero    = (req_id == '0);
    st.last_cand  = (bx + req_w == cols) && (by + req_h == rows);
    st.last_cell  = (ci + KW'(1) == req_w) && (cj + KW'(1) == req_h);
    st.eq_tgt     = (rd_data == (cmd.cmp_id ? req_id : '0));
    st.pos_in     = (bx < cols) && (by < rows);
    st.pos_last   = (bx + KW'(1) == cols) && (by + KW'(1) == rows);
    st.p_zero     = (bx == '0) && (by == '0);
    st.row0       = (by == '0);
    st.rd_zero    = (rd_data == '0);
    st.rd_id      = (rd_data == req_id);
    st.rd_eq_v    = (rd_data == v);
    st.sweep_last = (sweep == AW'(CELLS - 1));
    st.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res.result_code <= cmd.res_code;
      case (cmd.res_id_sel)
        IDS_V:   res.found_id <= 16'(v);
        IDS_RD:  res.found_id <= 16'(rd_data);
        default: res.found_id <= '0;
      endcase
      res.found_x <= cmd.res_pos ? bx[3:0] : 4'd0;
      res.found_y <= cmd.res_pos ? by[3:0] : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

/* rtl/grid_rectangle_allocator.sv */
// grid_rectangle_allocator: top level, controller plus datapath
// depends on gra_pkg, gra_ctrl, gra_datapath
//
// channel  direction  handshake            beat
// in       input      in_valid / in_stall  operation, position, id, size
// out      output     out_valid / out_stall result code, id, position
// cfg      input      cfg_valid / cfg_ready register index, value
//
// one request at a time, one grid cell read or written at a time through the
// single ram port; place and pick up first check every cell of the rectangle and
// then write each one, check room only checks, hold and find room check candidate
// positions in turn, next item scans cells, clear writes every cell
// after reset a clearing pass over all MAX_COLUMNS*MAX_ROWS cells runs before the
// first request is taken; a stalled result waits in the output register while
// the next request is already accepted
`default_nettype none
module grid_rectangle_allocator #(
  parameter int MAX_COLUMNS = gra_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gra_pkg::MAX_ROWS_DEF,
  parameter int ID_BITS     = gra_pkg::ID_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire gra_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output gra_pkg::out_t     out_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_index,
  input  wire logic [4:0]   cfg_data
);
  import gra_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  gra_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  gra_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
`default_nettype wire
